// ----- rtl/core/swlb_pkg.sv -----
// ----------------------------------------------------------------------------
// swlb_pkg: shared types and constants of the sorted write log buffer
// Sizes, entry and command types used by the cell chain and the top level.
// ----------------------------------------------------------------------------
package swlb_pkg;

   localparam int LOG_DEPTH   = 32;
   localparam int VALUE_WIDTH = 64;
   localparam int KEY_WIDTH   = 64;
   localparam int WORD_WIDTH  = 64;
   localparam int COUNT_WIDTH = $clog2(LOG_DEPTH + 1);

   localparam logic MODE_INSERT     = 1'b0;
   localparam logic MODE_CHECKPOINT = 1'b1;

   typedef logic [KEY_WIDTH-1:0]   key_type;
   typedef logic [VALUE_WIDTH-1:0] val_type;
   typedef logic [WORD_WIDTH-1:0]  word_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic    valid;
      key_type key;
      val_type value;
   } entry_type;

   typedef enum logic [1:0] {
      OP_IDLE,
      OP_INSERT,
      OP_SHIFT
   } chain_op_type;

   typedef struct packed {
      chain_op_type op;
      key_type      key;
      val_type      value;
   } chain_cmd_type;

   typedef struct packed {
      logic      lt;
      logic      eq;
      entry_type entry;
   } cell_stat_type;

endpackage

// ----- rtl/core/swlb_cell.sv -----
// ----------------------------------------------------------------------------
// swlb_cell: one slot of the sorted log
// Holds one key/value pair; on insert keeps, replaces, takes the new pair or
// takes its lower neighbor; on shift takes its upper neighbor.
// ----------------------------------------------------------------------------
module swlb_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  swlb_pkg::chain_cmd_type cmd,
   input  logic                   any_eq,
   input  swlb_pkg::cell_stat_type lo_stat,
   input  swlb_pkg::entry_type    hi_entry,
   output swlb_pkg::cell_stat_type stat
);
   import swlb_pkg::*;

   logic    valid_ff, valid_in;
   key_type key_ff, key_in;
   val_type value_ff, value_in;

   always_comb begin
      stat.entry.valid = valid_ff;
      stat.entry.key   = key_ff;
      stat.entry.value = value_ff;
      stat.lt          = valid_ff && (key_ff < cmd.key);
      stat.eq          = valid_ff && (key_ff == cmd.key);
   end

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      unique case (cmd.op)
         OP_INSERT: begin
            if (any_eq) begin
               if (stat.eq) begin
                  value_in = cmd.value;
               end
            end else if (!stat.lt) begin
               if (lo_stat.lt) begin
                  valid_in = 1'b1;
                  key_in   = cmd.key;
                  value_in = cmd.value;
               end else begin
                  valid_in = lo_stat.entry.valid;
                  key_in   = lo_stat.entry.key;
                  value_in = lo_stat.entry.value;
               end
            end
         end
         OP_SHIFT: begin
            valid_in = hi_entry.valid;
            key_in   = hi_entry.key;
            value_in = hi_entry.value;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

// ----- rtl/core/swlb_chain.sv -----
// ----------------------------------------------------------------------------
// swlb_chain: row of log cells
// Links the cells to their neighbors and folds the equal-key flags.
// Cell 0 holds the lowest key and is the drain head.
// ----------------------------------------------------------------------------
module swlb_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  swlb_pkg::chain_cmd_type cmd,
   output logic                    any_eq,
   output swlb_pkg::entry_type     head
);
   import swlb_pkg::*;

   cell_stat_type             stat [LOG_DEPTH];
   cell_stat_type             lo_stat [LOG_DEPTH];
   entry_type                 hi_entry [LOG_DEPTH];
   logic [LOG_DEPTH-1:0]      eq_bits;

   genvar gi;
   generate
      for (gi = 0; gi < LOG_DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_lo_edge
            assign lo_stat[gi] = '{lt: 1'b1, eq: 1'b0,
                                   entry: '{valid: 1'b1, key: '0, value: '0}};
         end else begin : g_lo_link
            assign lo_stat[gi] = stat[gi-1];
         end
         if (gi == LOG_DEPTH - 1) begin : g_hi_edge
            assign hi_entry[gi] = '0;
         end else begin : g_hi_link
            assign hi_entry[gi] = stat[gi+1].entry;
         end
         assign eq_bits[gi] = stat[gi].eq;

         swlb_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cmd      (cmd),
            .any_eq   (any_eq),
            .lo_stat  (lo_stat[gi]),
            .hi_entry (hi_entry[gi]),
            .stat     (stat[gi])
         );
      end
   endgenerate

   assign any_eq = |eq_bits;
   assign head   = stat[0].entry;

endmodule

// ----- rtl/core/sorted_write_log_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_write_log_buffer_unit: key-sorted write log in front of a store
// Buffers inserts in a sorted chain of cells, drains them in key order on
// checkpoint or when full, and passes inserts through with logging off.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tdata {value, key}, tuser mode
//   rsp_     out  rsp_tvalid/rsp_tready  tdata {out_value, out_key},
//                                        tuser is_entry, tlast last
//   csr_     in   csr_tvalid/csr_tready  tdata[0] log_enabled
//
// Insert into a non-full log, pass-through insert, marker-only checkpoint: done on accept.
// Checkpoint with held entries: accept, then each held entry in key order, then the marker.
// Insert into a full log: accept, drain of every held entry, then store of the new pair.
// Drain pace is set by the single output register; a stalled rsp_ freezes it.
// Synchronous reset empties the log; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_write_log_buffer_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] key, [127:64] value
   input  logic         req_tuser,   // [0] mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] out_key, [127:64] out_value
   output logic         rsp_tuser,   // [0] is_entry
   output logic         rsp_tlast,
   input  logic         csr_tvalid,
   output logic         csr_tready,
   input  logic [7:0]   csr_tdata    // [0] log_enabled
);
   import swlb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_MARK,
      ST_INSERT
   } state_type;

   state_type     state_ff;
   count_type     count_ff;
   logic          enabled_ff;
   logic          pend_insert_ff;
   key_type       pend_key_ff;
   val_type       pend_value_ff;
   logic          rsp_valid_ff;
   word_type      rsp_key_ff;
   word_type      rsp_value_ff;
   logic          rsp_entry_ff;
   logic          rsp_last_ff;

   chain_cmd_type cmd;
   logic          any_eq;
   entry_type     head;
   logic          slot_free;
   logic          req_fire;
   logic          is_full;
   key_type       req_key;
   val_type       req_value;

   assign req_key    = req_tdata[KEY_WIDTH-1:0];
   assign req_value  = req_tdata[KEY_WIDTH +: VALUE_WIDTH];
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;
   assign is_full    = (count_ff == COUNT_WIDTH'(LOG_DEPTH));
   assign csr_tready = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_value_ff, rsp_key_ff};
   assign rsp_tuser  = rsp_entry_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      cmd.op    = OP_IDLE;
      cmd.key   = req_key;
      cmd.value = req_value;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == MODE_INSERT && enabled_ff && !is_full) begin
               cmd.op = OP_INSERT;
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               cmd.op = OP_SHIFT;
            end
         end
         ST_INSERT: begin
            cmd.op    = OP_INSERT;
            cmd.key   = pend_key_ff;
            cmd.value = pend_value_ff;
         end
         default: begin
         end
      endcase
   end

   swlb_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .any_eq (any_eq),
      .head   (head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         enabled_ff     <= 1'b1;
         pend_insert_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_tvalid && csr_tready) begin
            enabled_ff <= csr_tdata[0];
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_tuser == MODE_CHECKPOINT) begin
                     if (enabled_ff && count_ff != '0) begin
                        pend_insert_ff <= 1'b0;
                        state_ff       <= ST_DRAIN;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        rsp_key_ff   <= '0;
                        rsp_value_ff <= '0;
                        rsp_entry_ff <= 1'b0;
                        rsp_last_ff  <= 1'b1;
                     end
                  end else if (!enabled_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_key_ff   <= word_type'(req_key);
                     rsp_value_ff <= word_type'(req_value);
                     rsp_entry_ff <= 1'b1;
                     rsp_last_ff  <= 1'b1;
                  end else if (is_full) begin
                     pend_insert_ff <= 1'b1;
                     pend_key_ff    <= req_key;
                     pend_value_ff  <= req_value;
                     state_ff       <= ST_DRAIN;
                  end else if (!any_eq) begin
                     count_ff <= count_ff + COUNT_WIDTH'(1);
                  end
               end
            end
            ST_DRAIN: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_key_ff   <= word_type'(head.key);
                  rsp_value_ff <= word_type'(head.value);
                  rsp_entry_ff <= 1'b1;
                  rsp_last_ff  <= pend_insert_ff && (count_ff == COUNT_WIDTH'(1));
                  count_ff     <= count_ff - COUNT_WIDTH'(1);
                  if (count_ff == COUNT_WIDTH'(1)) begin
                     state_ff <= pend_insert_ff ? ST_INSERT : ST_MARK;
                  end
               end
            end
            ST_MARK: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_key_ff   <= '0;
                  rsp_value_ff <= '0;
                  rsp_entry_ff <= 1'b0;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_INSERT: begin
               count_ff <= COUNT_WIDTH'(1);
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(LOG_DEPTH))
      else $error("entry count beyond log depth");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) == head.valid)
      else $error("head cell occupancy disagrees with entry count");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> count_ff != '0)
      else $error("drain with empty log");

   a_insert_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSERT |-> !head.valid && !any_eq)
      else $error("post-drain insert into non-empty log");
`endif

endmodule
